### hdl/mux_frame_receiver_fnv_defines.svh
// ----------------------------------------------------------------------------
// mux_frame_receiver_fnv_defines
// assertion macros used by the receiver top level
// ----------------------------------------------------------------------------
`ifndef MUX_FRAME_RECEIVER_FNV_DEFINES_SVH
`define MUX_FRAME_RECEIVER_FNV_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define MFRF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define MFRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MFRF_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFRF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hdl/mfrf_pkg.sv
// ----------------------------------------------------------------------------
// mfrf_pkg
// types, constants and the fnv-1a hash step of the channel deframer
// ----------------------------------------------------------------------------
`default_nettype none

package mfrf_pkg;

    localparam logic [7:0]  SYNC_BYTE  = 8'h67;
    localparam logic [31:0] FNV_BASIS  = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME  = 32'h01000193;
    localparam logic [7:0]  HASH_BYTES = 8'd4;
    localparam int          CHAN_W     = 6;
    localparam int          BIT_START  = 7;
    localparam int          BIT_END    = 6;

    // register indexes of the config port
    localparam logic CFG_CHANNEL_COUNT = 1'b0;
    localparam logic CFG_MAX_PAYLOAD   = 1'b1;

    // command queue between front and back, depth a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [2:0] {
        PH_SYNC     = 3'd0,
        PH_SYNC_BAD = 3'd1,
        PH_LEN      = 3'd2,
        PH_CTRL     = 3'd3,
        PH_PAYLOAD  = 3'd4,
        PH_HASH     = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_SYNC_ERR = 3'd1,
        OP_CTRL     = 3'd2,
        OP_PAYLOAD  = 3'd3,
        OP_CHECK    = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        KIND_PAYLOAD    = 3'd0,
        KIND_PACKET_OK  = 3'd1,
        KIND_FRAME_DONE = 3'd2,
        KIND_HASH_BAD   = 3'd3,
        KIND_NO_SYNC    = 3'd4
    } t_kind;

    typedef struct packed {
        logic [6:0] chan_limit;
        logic [7:0] max_payload;
    } t_cfg;

    // word: length for ctrl, payload byte, or the received hash for check
    typedef struct packed {
        t_op         op;
        logic        chv;
        logic [7:0]  ctl;
        logic [31:0] word;
    } t_cmd;

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        fnv_step = x * FNV_PRIME;
    endfunction

endpackage

`default_nettype wire

### hdl/mfrf_rx_if.sv
// ----------------------------------------------------------------------------
// mfrf_rx_if
// link byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface mfrf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### hdl/mfrf_res_if.sv
// ----------------------------------------------------------------------------
// mfrf_res_if
// result channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface mfrf_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [5:0] channel;
    logic [7:0] data;
    logic       first_of_frame;

    modport source (output valid, output kind, output channel, output data,
                    output first_of_frame, input ready);
    modport sink (input valid, input kind, input channel, input data,
                  input first_of_frame, output ready);
endinterface

`default_nettype wire

### hdl/mfrf_front.sv
// ----------------------------------------------------------------------------
// mfrf_front
// frame parser: sync hunt, length check, hash byte assembly, command issue
// ----------------------------------------------------------------------------
`default_nettype none

module mfrf_front
    import mfrf_pkg::*;
#(
    parameter int CHANNELS = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    mfrf_rx_if.sink    i_rx,
    output t_cmd       o_push_cmd,
    output logic       o_push_valid,
    input  wire logic  i_push_ready
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_ctl, n_ctl;
    logic [31:0] r_rhash, n_rhash;

    logic        accept;
    logic [7:0]  b;
    logic        chv_new, chv_cur;
    logic [1:0]  pos;
    logic [31:0] acc;
    t_phase      resync;
    t_cmd        cmd;

    assign b            = i_rx.rx_byte;
    assign accept       = i_rx.valid && i_push_ready;
    assign i_rx.ready   = i_push_ready;
    assign o_push_valid = i_rx.valid;
    assign o_push_cmd   = cmd;

    assign chv_new = ({1'b0, b[CHAN_W-1:0]} < i_cfg.chan_limit) &&
                     ({1'b0, b[CHAN_W-1:0]} < 7'(CHANNELS));
    assign chv_cur = ({1'b0, r_ctl[CHAN_W-1:0]} < i_cfg.chan_limit) &&
                     ({1'b0, r_ctl[CHAN_W-1:0]} < 7'(CHANNELS));

    // little-endian byte lane of the received hash
    assign pos    = 2'b00 - r_left[1:0];
    assign acc    = r_rhash | ({24'd0, b} << {pos, 3'b000});
    assign resync = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC;

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_left   = r_left;
        n_ctl    = r_ctl;
        n_rhash  = r_rhash;
        cmd.op   = OP_NOP;
        cmd.chv  = chv_cur;
        cmd.ctl  = r_ctl;
        cmd.word = 32'd0;
        unique case (r_phase)
            PH_SYNC_BAD: begin
                cmd.op  = OP_SYNC_ERR;
                n_phase = resync;
            end
            PH_LEN: begin
                if (b != 8'd0 && b <= i_cfg.max_payload) begin
                    n_len   = b;
                    n_left  = b;
                    n_phase = PH_CTRL;
                end else begin
                    cmd.op  = OP_SYNC_ERR;
                    n_phase = resync;
                end
            end
            PH_CTRL: begin
                n_ctl    = b;
                n_phase  = PH_PAYLOAD;
                cmd.op   = OP_CTRL;
                cmd.chv  = chv_new;
                cmd.ctl  = b;
                cmd.word = {24'd0, r_len};
            end
            PH_PAYLOAD: begin
                n_left   = r_left - 8'd1;
                cmd.op   = OP_PAYLOAD;
                cmd.word = {24'd0, b};
                if (n_left == 8'd0) begin
                    n_phase = PH_HASH;
                    n_left  = HASH_BYTES;
                    n_rhash = 32'd0;
                end
            end
            PH_HASH: begin
                n_left  = r_left - 8'd1;
                n_rhash = acc;
                if (!(n_left != 8'd0 && n_left <= HASH_BYTES)) begin
                    cmd.op   = OP_CHECK;
                    cmd.word = acc;
                    n_left   = 8'd0;
                    n_phase  = PH_SYNC;
                end
            end
            default: begin
                n_phase = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC;
            r_len   <= 8'd0;
            r_left  <= 8'd0;
            r_ctl   <= 8'd0;
            r_rhash <= 32'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_left  <= n_left;
            r_ctl   <= n_ctl;
            r_rhash <= n_rhash;
        end
    end

endmodule

`default_nettype wire

### hdl/mfrf_queue.sv
// ----------------------------------------------------------------------------
// mfrf_queue
// short command fifo between parser and executor
// ----------------------------------------------------------------------------
`default_nettype none

module mfrf_queue
    import mfrf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_push_cmd,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    output t_cmd       o_pop_cmd,
    output logic       o_pop_valid,
    input  wire logic  i_pop_ready
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push, pop;

    assign o_push_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/mfrf_back.sv
// ----------------------------------------------------------------------------
// mfrf_back
// executor: per-channel hash store, started flags and result register
// ----------------------------------------------------------------------------
`default_nettype none

module mfrf_back
    import mfrf_pkg::*;
#(
    parameter int CHANNELS = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire t_cmd  i_pop_cmd,
    input  wire logic  i_pop_valid,
    output logic       o_pop_ready,
    mfrf_res_if.source o_res
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [31:0]       r_hmem [CHANNELS];
    logic [CHANNELS-1:0] r_hvalid, n_hvalid;
    logic [CHANNELS-1:0] r_started, n_started;

    // stage b: command plus registered store read
    logic        r_b_valid;
    t_cmd        r_b_cmd;
    logic [31:0] r_b_rdata;
    logic        r_b_hv;
    // stage c: command plus hash after the length byte
    logic        r_c_valid;
    t_cmd        r_c_cmd;
    logic [31:0] r_c_h1;

    logic [31:0] r_hash, n_hash;
    logic        r_seen, n_seen;

    logic        r_out_valid;
    t_kind       r_out_kind, n_kind;
    logic [5:0]  r_out_chan, n_chan;
    logic [7:0]  r_out_data, n_data;
    logic        r_out_first, n_first;
    logic        emit;

    logic            en;
    logic [CH_W-1:0] rd_idx, c_idx;
    logic [31:0]     h0, n_h1, step;
    logic            wr_en;

    assign en          = !r_out_valid || o_res.ready;
    assign o_pop_ready = en;
    assign rd_idx      = i_pop_cmd.ctl[CH_W-1:0];
    assign c_idx       = r_c_cmd.ctl[CH_W-1:0];

    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_out_kind;
    assign o_res.channel        = r_out_chan;
    assign o_res.data           = r_out_data;
    assign o_res.first_of_frame = r_out_first;

    // a start bit restarts the hash; an entry never written reads as the basis
    always_comb begin
        if (r_b_cmd.chv && r_b_cmd.ctl[BIT_START]) begin
            h0 = FNV_BASIS;
        end else if (r_b_hv) begin
            h0 = r_b_rdata;
        end else begin
            h0 = FNV_BASIS;
        end
        n_h1 = r_b_cmd.chv ? fnv_step(h0, r_b_cmd.word[7:0]) : h0;
    end

    // ctrl hashes its own byte, payload its data byte
    assign step = (r_c_cmd.op == OP_CTRL) ? fnv_step(r_c_h1, r_c_cmd.ctl)
                                          : fnv_step(r_hash, r_c_cmd.word[7:0]);

    always_comb begin
        n_started = r_started;
        n_hvalid  = r_hvalid;
        n_hash    = r_hash;
        n_seen    = r_seen;
        wr_en     = 1'b0;
        emit      = 1'b0;
        n_kind    = KIND_PAYLOAD;
        n_chan    = r_c_cmd.ctl[CHAN_W-1:0];
        n_data    = 8'd0;
        n_first   = 1'b0;
        if (r_c_valid) begin
            unique case (r_c_cmd.op)
                OP_SYNC_ERR: begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (7'(i) < i_cfg.chan_limit) begin
                            n_started[i] = 1'b0;
                        end
                    end
                    emit   = 1'b1;
                    n_kind = KIND_NO_SYNC;
                    n_chan = 6'd0;
                end
                OP_CTRL: begin
                    n_seen = 1'b0;
                    // skipped channel still mirrors its stored hash
                    n_hash = r_c_h1;
                    if (r_c_cmd.chv) begin
                        n_hash          = step;
                        wr_en           = 1'b1;
                        n_hvalid[c_idx] = 1'b1;
                        if (r_c_cmd.ctl[BIT_START]) begin
                            n_started[c_idx] = 1'b1;
                        end
                    end
                end
                OP_PAYLOAD: begin
                    if (r_c_cmd.chv) begin
                        n_hash          = step;
                        wr_en           = 1'b1;
                        n_hvalid[c_idx] = 1'b1;
                        if (r_started[c_idx]) begin
                            emit    = 1'b1;
                            n_kind  = KIND_PAYLOAD;
                            n_data  = r_c_cmd.word[7:0];
                            n_first = r_c_cmd.ctl[BIT_START] && !r_seen;
                            n_seen  = 1'b1;
                        end
                    end
                end
                OP_CHECK: begin
                    if (r_c_cmd.chv) begin
                        emit = 1'b1;
                        priority if (r_hash != r_c_cmd.word) begin
                            n_started[c_idx] = 1'b0;
                            n_kind           = KIND_HASH_BAD;
                        end else if (r_started[c_idx] && r_c_cmd.ctl[BIT_END]) begin
                            n_started[c_idx] = 1'b0;
                            n_kind           = KIND_FRAME_DONE;
                        end else begin
                            n_kind = KIND_PACKET_OK;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // hash store
    always_ff @(posedge i_clk) begin
        if (en && wr_en) begin
            r_hmem[c_idx] <= n_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_rdata <= r_hmem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_cmd     <= i_pop_cmd;
            r_b_hv      <= r_hvalid[rd_idx];
            r_c_cmd     <= r_b_cmd;
            r_c_h1      <= n_h1;
            r_hash      <= n_hash;
            r_out_kind  <= n_kind;
            r_out_chan  <= n_chan;
            r_out_data  <= n_data;
            r_out_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_hvalid    <= '0;
            r_started   <= '0;
            r_seen      <= 1'b0;
        end else if (en) begin
            r_b_valid   <= i_pop_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid && emit;
            r_hvalid    <= n_hvalid;
            r_started   <= n_started;
            r_seen      <= n_seen;
        end
    end

endmodule

`default_nettype wire

### hdl/mux_frame_receiver_fnv.sv
// a byte's result passes the command queue, then stage b, stage c and the result register
// throughput: one byte per cycle while the command queue has room; the executor applies one hash step per stage
//   and reads the per-channel hash store through a single registered port
// a four-entry command queue lets the parser run on while results stall
// reset: synchronous, active low; hash entries read as the offset basis through
//   per-channel valid bits, so no clearing pass is needed
// ----------------------------------------------------------------------------
// mux_frame_receiver_fnv
// channel multiplexing deframer with per-channel fnv-1a-32 checks
// ----------------------------------------------------------------------------
`default_nettype none

`include "mux_frame_receiver_fnv_defines.svh"

module mux_frame_receiver_fnv
    import mfrf_pkg::*;
#(
    parameter int CHANNELS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    mfrf_rx_if.sink         i_rx,
    mfrf_res_if.source      o_res
);

    t_cfg r_cfg;
    t_cmd push_cmd, pop_cmd;
    logic push_valid, push_ready, pop_valid, pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chan_limit  <= 7'd1;
            r_cfg.max_payload <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHANNEL_COUNT: r_cfg.chan_limit  <= i_cfg_data[6:0];
                CFG_MAX_PAYLOAD:   r_cfg.max_payload <= i_cfg_data;
                default:           r_cfg             <= r_cfg;
            endcase
        end
    end

    mfrf_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_rx         (i_rx),
        .o_push_cmd   (push_cmd),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready)
    );

    mfrf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cmd   (push_cmd),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .o_pop_cmd    (pop_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready)
    );

    mfrf_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_cmd   (pop_cmd),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .o_res       (o_res)
    );

    `MFRF_ASSERT(a_status_no_data, i_clk, i_rst_n, o_res.valid && o_res.kind != KIND_PAYLOAD |-> o_res.data == 8'd0 && !o_res.first_of_frame, "status word carries payload bits")
    `MFRF_ASSERT(a_sync_chan_zero, i_clk, i_rst_n, o_res.valid && o_res.kind == KIND_NO_SYNC |-> o_res.channel == 6'd0, "sync error word carries a channel")
    `MFRF_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_res.valid, "result valid after reset")

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the channel deframer with per-channel fnv-1a hashes
// link bytes are generated from the predicted parser state, so most of them
// form well-framed packets with random content, sprinkled with sync noise,
// bad lengths and corrupted hashes; every result word is checked in order
// against a predictor running in a scoreboard
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import mfrf_pkg::*;

    typedef struct {
        t_kind      kind;
        logic [5:0] chan;
        logic [7:0] data;
        logic       first;
    } deframe_result_t;

    function automatic logic [31:0] fnv1a(input logic [31:0] h, input logic [7:0] b);
        return (h ^ {24'd0, b}) * FNV_PRIME;
    endfunction

    class deframe_scoreboard;
        t_phase          phase;
        logic [7:0]      pay_len;
        logic [7:0]      left;
        logic [7:0]      ctrl;
        logic [31:0]     rx_hash;
        bit              seen;
        logic [31:0]     chash [64];
        bit              started [64];
        logic [6:0]      n_chan;
        logic [7:0]      max_len;
        deframe_result_t due_results [$];
        int              errors;

        function new();
            phase   = PH_SYNC;
            pay_len = '0;
            left    = '0;
            ctrl    = '0;
            rx_hash = '0;
            seen    = 1'b0;
            n_chan  = 7'd1;
            max_len = 8'd255;
            errors  = 0;
            foreach (chash[i]) begin
                chash[i]   = FNV_BASIS;
                started[i] = 1'b0;
            end
        endfunction

        function void set_reg(input logic idx, input logic [7:0] val);
            if (idx == CFG_CHANNEL_COUNT) begin
                n_chan = val[6:0];
            end else begin
                max_len = val;
            end
        endfunction

        function bit in_use(input logic [5:0] ch);
            return {1'b0, ch} < n_chan;
        endfunction

        // drops every channel in use out of its frame
        function void sync_lost(input logic [7:0] b);
            foreach (started[i]) begin
                if (i < n_chan) started[i] = 1'b0;
            end
            phase = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC;
        endfunction

        function void take_byte(input logic [7:0] b);
            deframe_result_t r;
            bit              has_r;
            logic [5:0]      ch;
            logic [1:0]      slot;
            r     = '{KIND_PAYLOAD, 6'd0, 8'd0, 1'b0};
            has_r = 1'b0;
            ch    = ctrl[5:0];
            case (phase)
                PH_SYNC_BAD: begin
                    sync_lost(b);
                    r.kind = KIND_NO_SYNC;
                    has_r  = 1'b1;
                end
                PH_LEN: begin
                    if (b != 8'd0 && b <= max_len) begin
                        pay_len = b;
                        left    = b;
                        phase   = PH_CTRL;
                    end else begin
                        sync_lost(b);
                        r.kind = KIND_NO_SYNC;
                        has_r  = 1'b1;
                    end
                end
                PH_CTRL: begin
                    ctrl  = b;
                    seen  = 1'b0;
                    phase = PH_PAYLOAD;
                    ch    = b[5:0];
                    if (in_use(ch)) begin
                        if (b[BIT_START]) begin
                            started[ch] = 1'b1;
                            chash[ch]   = FNV_BASIS;
                        end
                        chash[ch] = fnv1a(fnv1a(chash[ch], pay_len), b);
                    end
                end
                PH_PAYLOAD: begin
                    left = left - 8'd1;
                    if (left == 8'd0) begin
                        phase   = PH_HASH;
                        left    = HASH_BYTES;
                        rx_hash = '0;
                    end
                    if (in_use(ch)) begin
                        chash[ch] = fnv1a(chash[ch], b);
                        if (started[ch]) begin
                            r     = '{KIND_PAYLOAD, ch, b, ctrl[BIT_START] && !seen};
                            seen  = 1'b1;
                            has_r = 1'b1;
                        end
                    end
                end
                PH_HASH: begin
                    // hash arrives little-endian
                    slot    = 2'(8'd4 - left);
                    rx_hash = rx_hash | (32'(b) << (8 * slot));
                    left    = left - 8'd1;
                    if (left == 8'd0 || left > 8'd4) begin
                        left  = '0;
                        phase = PH_SYNC;
                        if (in_use(ch)) begin
                            has_r  = 1'b1;
                            r.chan = ch;
                            if (chash[ch] != rx_hash) begin
                                started[ch] = 1'b0;
                                r.kind      = KIND_HASH_BAD;
                            end else if (started[ch] && ctrl[BIT_END]) begin
                                started[ch] = 1'b0;
                                r.kind      = KIND_FRAME_DONE;
                            end else begin
                                r.kind = KIND_PACKET_OK;
                            end
                        end
                    end
                end
                default: begin
                    phase = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC_BAD;
                end
            endcase
            if (has_r) due_results.push_back(r);
        endfunction

        function void check_result(input logic [2:0] kind, input logic [5:0] ch,
                                   input logic [7:0] data, input logic first);
            deframe_result_t want;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: kind %0d ch %0d data %02h first %0b",
                             kind, ch, data, first);
                return;
            end
            want = due_results.pop_front();
            if (want.kind !== kind || want.chan !== ch || want.data !== data ||
                want.first !== first) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: want kind %0d ch %0d data %02h first %0b, %s",
                             want.kind, want.chan, want.data, want.first,
                             $sformatf("got kind %0d ch %0d data %02h first %0b",
                                       kind, ch, data, first));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [7:0] i_cfg_data;

    mfrf_rx_if  rx_if ();
    mfrf_res_if res_if ();

    deframe_scoreboard sb;
    bit idle_en;
    bit hold_req;

    // per random phase: channel count, max payload, byte count, idling
    int chan_tab [7] = '{4, 64, 1, 0, 127, 16, 3};
    int plen_tab [7] = '{12, 255, 1, 6, 3, 0, 20};
    int size_tab [7] = '{220, 260, 150, 80, 150, 40, 500};
    bit idle_tab [7] = '{1, 1, 0, 1, 1, 1, 0};

    mux_frame_receiver_fnv #(
        .CHANNELS (64)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_if),
        .o_res      (res_if)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready) sb.take_byte(rx_if.rx_byte);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.kind, res_if.channel, res_if.data,
                                res_if.first_of_frame);
        end
    end

    // next hash byte that matches the predicted channel hash
    function automatic logic [7:0] due_hash_byte();
        logic [31:0] h;
        logic [1:0]  slot;
        h    = sb.chash[sb.ctrl[5:0]];
        slot = 2'(8'd4 - sb.left);
        return 8'(h >> (8 * slot));
    endfunction

    // chooses a link byte from the parser state: mostly good framing
    function automatic logic [7:0] pick_byte();
        int         r;
        int         lim;
        logic [7:0] b;
        logic [5:0] ch;
        bit         st;
        bit         en;
        r = $urandom_range(0, 99);
        case (sb.phase)
            PH_SYNC: begin
                b = (r < 88) ? SYNC_BYTE : 8'($urandom_range(0, 255));
            end
            PH_SYNC_BAD: begin
                b = (r < 50) ? SYNC_BYTE : 8'($urandom_range(0, 255));
            end
            PH_LEN: begin
                if (sb.max_len == 8'd0) begin
                    b = 8'($urandom_range(0, 255));
                end else if (r < 5) begin
                    b = 8'd0;
                end else if (r < 9) begin
                    b = (sb.max_len == 8'hff) ? 8'd0 :
                        8'($urandom_range(int'(sb.max_len) + 1, 255));
                end else if (r < 11) begin
                    b = sb.max_len;
                end else begin
                    b = 8'($urandom_range(1, (sb.max_len < 8'd6) ? int'(sb.max_len) : 6));
                end
            end
            PH_CTRL: begin
                lim = (sb.n_chan == 7'd0 || sb.n_chan > 7'd64) ? 64 : int'(sb.n_chan);
                // a few channels carry most traffic so frames get completed
                if (r < 65)
                    ch = 6'($urandom_range(0, (lim < 4) ? lim - 1 : 3));
                else if (r < 85)
                    ch = 6'($urandom_range(0, lim - 1));
                else
                    ch = 6'($urandom_range(0, 63));
                st = ($urandom_range(0, 99) < 45);
                en = ($urandom_range(0, 99) < 40);
                b  = {st, en, ch};
            end
            PH_HASH: begin
                b = due_hash_byte();
                if (r < 2) b = b ^ 8'($urandom_range(1, 255));
            end
            default: begin
                b = 8'($urandom_range(0, 255));
            end
        endcase
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_packet(input logic [7:0] len, input logic [7:0] ctl,
                               input logic [7:0] fill, input bit good);
        send_byte(SYNC_BYTE);
        send_byte(len);
        send_byte(ctl);
        repeat (len) send_byte(fill);
        repeat (4) send_byte(good ? due_hash_byte() : ~due_hash_byte());
    endtask

    // a byte can leave no word behind, so allow the pipeline to drain as well
    task automatic settle();
        rx_if.valid <= 1'b0;
        while (sb.due_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        sb.set_reg(idx, val);
    endtask

    initial begin : result_sink
        int burst;
        int hold_left;
        burst        = 0;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                res_if.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(0, 10);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_CHANNEL_COUNT;
        i_cfg_data    = 8'd0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'd0;
        idle_en       = 1'b1;
        hold_req      = 1'b0;
        sb            = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset config: only channel 0 in use
        send_packet(8'd1, 8'hc0, 8'hff, 1'b1);
        // bad pair ending in sync, then a zero length
        send_byte(8'h12);
        send_byte(SYNC_BYTE);
        send_byte(8'h00);
        // channel not started: hash still checked
        send_packet(8'd1, 8'h00, 8'h00, 1'b1);
        // channel above the count walks through silently
        send_packet(8'd1, 8'hff, 8'h80, 1'b1);
        send_packet(8'd2, 8'h80, 8'h5a, 1'b0);

        for (int p = 0; p < 7; p++) begin
            settle();
            write_reg(CFG_CHANNEL_COUNT, 8'(chan_tab[p]));
            write_reg(CFG_MAX_PAYLOAD, 8'(plen_tab[p]));
            i_cfg_we <= 1'b0;
            idle_en = idle_tab[p];
            // long result stall while bytes keep coming
            if (p == 0) hold_req = 1'b1;
            repeat (size_tab[p]) send_byte(pick_byte());
        end

        settle();
        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+hdl
hdl/mfrf_pkg.sv
hdl/mfrf_rx_if.sv
hdl/mfrf_res_if.sv
hdl/mfrf_front.sv
hdl/mfrf_queue.sv
hdl/mfrf_back.sv
hdl/mux_frame_receiver_fnv.sv
test/tb.sv
